/* rtl/mqtt_packet_deframer_unit_defines.svh */
// Assertion macros for the deframer.
`ifndef MQTT_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define MQTT_PACKET_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MQTTD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: label");
`define MQTTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define MQTTD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MQTTD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/mqttd_pkg.sv */
`timescale 1ns / 1ps
package mqttd_pkg;

  localparam logic [3:0] ROLE_HEADER    = 4'd0;
  localparam logic [3:0] ROLE_LENGTH    = 4'd1;
  localparam logic [3:0] ROLE_TOPIC_LEN = 4'd2;
  localparam logic [3:0] ROLE_TOPIC     = 4'd3;
  localparam logic [3:0] ROLE_PKT_ID    = 4'd4;
  localparam logic [3:0] ROLE_PAYLOAD   = 4'd5;
  localparam logic [3:0] ROLE_BODY      = 4'd6;
  localparam logic [3:0] ROLE_CONNACK   = 4'd7;
  localparam logic [3:0] ROLE_DISCARD   = 4'd8;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_DISCARD   = 2'd3;

  localparam logic [3:0] TYPE_CONNACK = 4'd2;
  localparam logic [3:0] TYPE_PUBLISH = 4'd3;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       start_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [3:0]  role;
    logic [3:0]  packet_type;
    logic [3:0]  packet_flags;
    logic        retain;
    logic [27:0] body_length;
    logic        last_of_packet;
    logic [1:0]  status;
  } out_item_t;

endpackage

/* rtl/mqttd_if.sv */
`timescale 1ns / 1ps
interface mqttd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       start_of_stream;

  modport source (output valid, output byte_in, output start_of_stream, input ready);
  modport sink (input valid, input byte_in, input start_of_stream, output ready);
endinterface

interface mqttd_tag_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [3:0]  role;
  logic [3:0]  packet_type;
  logic [3:0]  packet_flags;
  logic        retain;
  logic [27:0] body_length;
  logic        last_of_packet;
  logic [1:0]  status;

  modport source (output valid, output byte_out, output role, output packet_type,
                  output packet_flags, output retain, output body_length,
                  output last_of_packet, output status, input ready);
  modport sink (input valid, input byte_out, input role, input packet_type,
                input packet_flags, input retain, input body_length,
                input last_of_packet, input status, output ready);
endinterface

/* rtl/mqttd_stage.sv */
`timescale 1ns / 1ps
module mqttd_stage #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  T     data_i,
  output logic valid_o,
  input  logic ready_i,
  output T     data_o
);

  logic valid_q;
  T     data_q;

  // take a new word when empty, or whenever the held one leaves in the same cycle
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

/* rtl/mqttd_tagger.sv */
`timescale 1ns / 1ps
module mqttd_tagger import mqttd_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  output out_item_t res_o
);

  localparam logic [2:0] PH_HEADER    = 3'd0;
  localparam logic [2:0] PH_LENGTH    = 3'd1;
  localparam logic [2:0] PH_TOPIC_LEN = 3'd2;
  localparam logic [2:0] PH_TOPIC     = 3'd3;
  localparam logic [2:0] PH_PKT_ID    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD   = 3'd5;
  localparam logic [2:0] PH_BODY      = 3'd6;
  localparam logic [2:0] PH_DISCARD   = 3'd7;

  logic [2:0]  phase_q, phase_d, phase_c;
  logic [27:0] accum_q, accum_d, accum_c;
  logic [2:0]  lbs_q, lbs_d, lbs_c;
  logic [27:0] remain_q, remain_d, remain_c;
  logic [3:0]  type_q, type_d, type_c;
  logic [3:0]  flags_q, flags_d, flags_c;
  logic [15:0] topic_q, topic_d, topic_c;
  logic [7:0]  tlen_hi_q, tlen_hi_d, tlen_hi_c;
  logic [1:0]  sub_q, sub_d, sub_c;
  logic        err_q, err_d, err_c;

  logic [7:0]  b;
  logic [27:0] addend;
  logic [2:0]  after_topic;
  logic [3:0]  role;
  logic [1:0]  status;
  logic        last;
  logic        incomplete;

  assign b = item_i.byte_in;

  always_comb begin
    // start of stream clears everything before this word
    if (item_i.start_of_stream) begin
      phase_c   = PH_HEADER;
      accum_c   = '0;
      lbs_c     = '0;
      remain_c  = '0;
      type_c    = '0;
      flags_c   = '0;
      topic_c   = '0;
      tlen_hi_c = '0;
      sub_c     = '0;
      err_c     = 1'b0;
    end else begin
      phase_c   = phase_q;
      accum_c   = accum_q;
      lbs_c     = lbs_q;
      remain_c  = remain_q;
      type_c    = type_q;
      flags_c   = flags_q;
      topic_c   = topic_q;
      tlen_hi_c = tlen_hi_q;
      sub_c     = sub_q;
      err_c     = err_q;
    end
  end

  always_comb begin
    case (lbs_c[1:0])
      2'd0:    addend = {21'd0, b[6:0]};
      2'd1:    addend = {14'd0, b[6:0], 7'd0};
      2'd2:    addend = {7'd0, b[6:0], 14'd0};
      default: addend = {b[6:0], 21'd0};
    endcase
  end

  assign after_topic = (flags_c[2:1] != 2'd0) ? PH_PKT_ID : PH_PAYLOAD;

  always_comb begin
    phase_d    = phase_c;
    accum_d    = accum_c;
    lbs_d      = lbs_c;
    remain_d   = remain_c;
    type_d     = type_c;
    flags_d    = flags_c;
    topic_d    = topic_c;
    tlen_hi_d  = tlen_hi_c;
    sub_d      = sub_c;
    err_d      = err_c;
    role       = ROLE_HEADER;
    status     = ST_OK;
    last       = 1'b0;
    incomplete = 1'b0;

    if (err_c || phase_c == PH_DISCARD) begin
      err_d   = 1'b1;
      phase_d = PH_DISCARD;
      role    = ROLE_DISCARD;
      status  = ST_DISCARD;
    end else if (phase_c == PH_HEADER) begin
      type_d  = b[7:4];
      flags_d = b[3:0];
      accum_d = '0;
      lbs_d   = '0;
      role    = ROLE_HEADER;
      phase_d = PH_LENGTH;
    end else if (phase_c == PH_LENGTH) begin
      role = ROLE_LENGTH;
      if (lbs_c < 3'd4) begin
        accum_d = accum_c + addend;
      end
      lbs_d = lbs_c + 3'd1;
      if (b[7]) begin
        if (lbs_d >= 3'(MAX_LENGTH_BYTES)) begin
          status  = ST_MALFORMED;
          err_d   = 1'b1;
          phase_d = PH_DISCARD;
        end
      end else begin
        remain_d = accum_d;
        sub_d    = '0;
        if (accum_d == '0) begin
          last = 1'b1;
          if (type_c == TYPE_PUBLISH) begin
            status = ST_TRUNCATED;
          end
          phase_d = PH_HEADER;
        end else if (type_c == TYPE_PUBLISH) begin
          phase_d = PH_TOPIC_LEN;
        end else begin
          phase_d = PH_BODY;
        end
      end
    end else begin
      case (phase_c)
        PH_TOPIC_LEN: begin
          role = ROLE_TOPIC_LEN;
          if (sub_c == 2'd0) begin
            tlen_hi_d  = b;
            sub_d      = 2'd1;
            incomplete = 1'b1;
          end else begin
            topic_d = {tlen_hi_c, b};
            sub_d   = 2'd0;
            if (topic_d != '0) begin
              phase_d    = PH_TOPIC;
              incomplete = 1'b1;
            end else begin
              phase_d    = after_topic;
              incomplete = (after_topic == PH_PKT_ID);
            end
          end
        end
        PH_TOPIC: begin
          role    = ROLE_TOPIC;
          topic_d = topic_c - 16'd1;
          if (topic_d == '0) begin
            phase_d    = after_topic;
            incomplete = (after_topic == PH_PKT_ID);
          end else begin
            incomplete = 1'b1;
          end
        end
        PH_PKT_ID: begin
          role = ROLE_PKT_ID;
          if (sub_c == 2'd0) begin
            sub_d      = 2'd1;
            incomplete = 1'b1;
          end else begin
            sub_d   = 2'd0;
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          role = ROLE_PAYLOAD;
        end
        default: begin
          role = ROLE_BODY;
          if (type_c == TYPE_CONNACK) begin
            if (sub_c == 2'd1) begin
              role = ROLE_CONNACK;
            end
            if (sub_c < 2'd2) begin
              sub_d = sub_c + 2'd1;
            end
          end
        end
      endcase
      remain_d = remain_c - 28'd1;
      if (remain_d == '0) begin
        last = 1'b1;
        if (type_c == TYPE_PUBLISH && incomplete) begin
          status = ST_TRUNCATED;
        end
        phase_d = PH_HEADER;
        sub_d   = '0;
      end
    end
  end

  always_comb begin
    res_o.byte_out       = b;
    res_o.role           = role;
    res_o.packet_type    = type_d;
    res_o.packet_flags   = flags_d;
    res_o.retain         = flags_d[0];
    res_o.body_length    = accum_d;
    res_o.last_of_packet = last;
    res_o.status         = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      accum_q   <= '0;
      lbs_q     <= '0;
      remain_q  <= '0;
      type_q    <= '0;
      flags_q   <= '0;
      topic_q   <= '0;
      tlen_hi_q <= '0;
      sub_q     <= '0;
      err_q     <= 1'b0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      accum_q   <= accum_d;
      lbs_q     <= lbs_d;
      remain_q  <= remain_d;
      type_q    <= type_d;
      flags_q   <= flags_d;
      topic_q   <= topic_d;
      tlen_hi_q <= tlen_hi_d;
      sub_q     <= sub_d;
      err_q     <= err_d;
    end
  end

endmodule

/* rtl/mqtt_packet_deframer_unit.sv */
`timescale 1ns / 1ps
// Channel   Dir  Word
// byte_i    in   one received stream byte, start_of_stream flag
// tag_o     out  byte, role, type, flags, retain, length, last, status
//
// One word per cycle sustained while tag_o is ready; a word in the input register moves
// to the result register once that register has room, and is offered on tag_o from then.
// Parser state advances once per word as it moves from input to result register.
// rst_ni empties both registers and clears the parser state at once; no clearing pass.
// A stall on tag_o fills the result register, then the input register, then
// drops byte_i.ready.
`include "mqtt_packet_deframer_unit_defines.svh"
module mqtt_packet_deframer_unit import mqttd_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mqttd_byte_if.sink    byte_i,
  mqttd_tag_if.source   tag_o
);

  in_item_t  in_item;
  in_item_t  mid_item;
  out_item_t res_item;
  out_item_t out_item;
  logic      mid_valid;
  logic      mid_ready;
  logic      out_valid;

  assign in_item.byte_in         = byte_i.byte_in;
  assign in_item.start_of_stream = byte_i.start_of_stream;

  mqttd_stage #(.T(in_item_t)) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (byte_i.valid),
    .ready_o (byte_i.ready),
    .data_i  (in_item),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .data_o  (mid_item)
  );

  mqttd_tagger #(.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)) u_tagger (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (mid_valid && mid_ready),
    .item_i (mid_item),
    .res_o  (res_item)
  );

  mqttd_stage #(.T(out_item_t)) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .data_i  (res_item),
    .valid_o (out_valid),
    .ready_i (tag_o.ready),
    .data_o  (out_item)
  );

  assign tag_o.valid          = out_valid;
  assign tag_o.byte_out       = out_item.byte_out;
  assign tag_o.role           = out_item.role;
  assign tag_o.packet_type    = out_item.packet_type;
  assign tag_o.packet_flags   = out_item.packet_flags;
  assign tag_o.retain         = out_item.retain;
  assign tag_o.body_length    = out_item.body_length;
  assign tag_o.last_of_packet = out_item.last_of_packet;
  assign tag_o.status         = out_item.status;

  // a word moving out of the input register lands in the result register
  `MQTTD_ASSERT_NEXT(a_word_lands, clk_i, rst_ni, mid_valid && mid_ready, out_valid)
  // malformed length is reported on a length byte, never as packet end
  `MQTTD_ASSERT_IMPLY(a_malformed_on_length, clk_i, rst_ni,
    out_valid && out_item.status == ST_MALFORMED,
    out_item.role == ROLE_LENGTH && !out_item.last_of_packet)
  // a discarded byte always reports the discarding status
  `MQTTD_ASSERT_IMPLY(a_discard_status, clk_i, rst_ni,
    out_valid && out_item.role == ROLE_DISCARD, out_item.status == ST_DISCARD)
  // after a malformed length, the next word without a fresh stream is discarded
  `MQTTD_ASSERT_NEXT(a_error_sticks, clk_i, rst_ni,
    mid_valid && mid_ready && res_item.status == ST_MALFORMED,
    !(mid_valid && mid_ready && !mid_item.start_of_stream) ||
    res_item.role == ROLE_DISCARD)

endmodule
